>>> design/ppmp_pkg.sv
// Shared types, codes and constants for the pad poller with multitap.
// Used by every module of the poller; depends on nothing.
package ppmp_pkg;

    localparam int PAD_COUNT_DEF = 4;
    localparam int STATE_BYTES   = 6;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    localparam logic RESULT_CMD    = 1'b0;
    localparam logic RESULT_REPORT = 1'b1;

    localparam logic [1:0] FRAME_CONT = 2'd0;
    localparam logic [1:0] FRAME_NEW  = 2'd1;
    localparam logic [1:0] FRAME_DONE = 2'd2;

    localparam logic [7:0] CMD_NONE  = 8'h00;
    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_POLL  = 8'h42;
    localparam logic [7:0] CMD_MTAP  = 8'h01;

    localparam logic [7:0] TYPE_DIGITAL = 8'h41;
    localparam logic [7:0] TYPE_ANALOG  = 8'h73;
    localparam logic [7:0] TYPE_ANAGRN  = 8'h53;
    localparam logic [7:0] MTAP_ID      = 8'h80;
    localparam logic [7:0] AXIS_CENTRE  = 8'd127;

    localparam logic [5:0] FRAME1_LEN  = 6'd9;
    localparam logic [5:0] FRAME2_HEAD = 6'd3;

    localparam logic [3:0] HAT_CENTRE     = 4'd0;
    localparam logic [3:0] HAT_UP         = 4'd1;
    localparam logic [3:0] HAT_UP_RIGHT   = 4'd2;
    localparam logic [3:0] HAT_RIGHT      = 4'd3;
    localparam logic [3:0] HAT_DOWN_RIGHT = 4'd4;
    localparam logic [3:0] HAT_DOWN       = 4'd5;
    localparam logic [3:0] HAT_DOWN_LEFT  = 4'd6;
    localparam logic [3:0] HAT_LEFT       = 4'd7;
    localparam logic [3:0] HAT_UP_LEFT    = 4'd8;

    typedef logic [STATE_BYTES-1:0][7:0] pad_bytes_t;

    localparam pad_bytes_t BYTES_RESET = '{8'd127, 8'd127, 8'd127, 8'd127, 8'd0, 8'd0};

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  cmd_byte;
        logic [1:0]  frame_ctl;
        logic [1:0]  pad_index;
        logic [11:0] buttons;
        logic        menu;
        logic [3:0]  hat;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       wr_en;
        logic       scan_en;
        logic [1:0] pad;
        logic [2:0] off;
        logic [7:0] data;
    } store_cmd_t;

endpackage

>>> design/ppmp_report_fmt.sv
// Report formatter: maps one pad's stored bytes to buttons, menu, hat and axes.
// Depends on ppmp_pkg.
module ppmp_report_fmt
(
    input  ppmp_pkg::pad_bytes_t bytes,
    input  logic [1:0]           pad,
    output ppmp_pkg::result_t    report
);

    logic [15:0] w;
    logic        menu_hit;

    assign w        = {bytes[1], bytes[0]};
    assign menu_hit = w[3] & w[0];

    always_comb
    begin
        report             = '0;
        report.result_kind = ppmp_pkg::RESULT_REPORT;
        report.pad_index   = pad;
        report.menu        = menu_hit;
        if (!menu_hit)
        begin
            report.buttons = {w[1], w[2], w[0], w[3], w[8], w[10],
                              w[9], w[11], w[12], w[15], w[14], w[13]};
        end
        if (w[6])
        begin
            report.hat = w[5] ? ppmp_pkg::HAT_DOWN_RIGHT :
                         (w[7] ? ppmp_pkg::HAT_DOWN_LEFT : ppmp_pkg::HAT_DOWN);
        end
        else if (w[4])
        begin
            report.hat = w[5] ? ppmp_pkg::HAT_UP_RIGHT :
                         (w[7] ? ppmp_pkg::HAT_UP_LEFT : ppmp_pkg::HAT_UP);
        end
        else if (w[5])
        begin
            report.hat = ppmp_pkg::HAT_RIGHT;
        end
        else if (w[7])
        begin
            report.hat = ppmp_pkg::HAT_LEFT;
        end
        else
        begin
            report.hat = ppmp_pkg::HAT_CENTRE;
        end
        report.left_x  = bytes[4];
        report.left_y  = bytes[5];
        report.right_x = bytes[2];
        report.right_y = bytes[3];
    end

endmodule

>>> design/ppmp_pad_store.sv
// Per-pad storage of type, current bytes and last reported bytes, with the
// shared axis-forcing and compare unit that the end-of-poll scan steps through.
// Depends on ppmp_pkg.
module ppmp_pad_store #(
    parameter int PAD_COUNT = ppmp_pkg::PAD_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppmp_pkg::store_cmd_t  cmd,
    output ppmp_pkg::pad_bytes_t  rd_bytes,
    output logic                  scan_hit
);

    localparam int PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    logic [7:0]           type_reg  [PAD_COUNT];
    ppmp_pkg::pad_bytes_t bytes_reg [PAD_COUNT];
    ppmp_pkg::pad_bytes_t rep_reg   [PAD_COUNT];

    logic [PAD_W-1:0]     sel;
    logic                 in_range;
    logic [7:0]           typ;
    logic                 analog;
    ppmp_pkg::pad_bytes_t forced;
    logic [2:0]           slot;

    assign sel      = cmd.pad[PAD_W-1:0];
    assign in_range = ({1'b0, cmd.pad} < 3'(PAD_COUNT));
    assign typ      = type_reg[sel];
    assign analog   = (typ == ppmp_pkg::TYPE_ANALOG) || (typ == ppmp_pkg::TYPE_ANAGRN);
    assign rd_bytes = bytes_reg[sel];
    assign slot     = 3'(cmd.off - 3'd2);

    always_comb
    begin
        forced = bytes_reg[sel];
        if (!analog)
        begin
            for (int j = 2; j < ppmp_pkg::STATE_BYTES; j++)
            begin
                forced[j] = ppmp_pkg::AXIS_CENTRE;
            end
        end
        scan_hit = (analog || (typ == ppmp_pkg::TYPE_DIGITAL)) && (forced != rep_reg[sel]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                type_reg[p]  <= '0;
                bytes_reg[p] <= ppmp_pkg::BYTES_RESET;
                rep_reg[p]   <= ppmp_pkg::BYTES_RESET;
            end
        end
        else if (cmd.wr_en && in_range)
        begin
            if (cmd.off == 3'd0)
            begin
                type_reg[sel] <= cmd.data;
            end
            else if ((cmd.off == 3'd2) || (cmd.off == 3'd3))
            begin
                bytes_reg[sel][slot] <= ~cmd.data;
            end
            else if (cmd.off >= 3'd4)
            begin
                bytes_reg[sel][slot] <= cmd.data;
            end
        end
        else if (cmd.scan_en)
        begin
            bytes_reg[sel] <= forced;
            if (scan_hit)
            begin
                rep_reg[sel] <= forced;
            end
        end
    end

endmodule

>>> design/psx_pad_multitap_poller_core.sv
// Pad poller with multitap: one input word is taken at a time and the input stays stalled
// until its last word is in the output register. A command word is loaded in S_STEP after
// acceptance, once the output is free. A poll-ending byte passes S_STEP, then S_SCAN steps
// through every pad on the shared compare unit; the finish word is loaded in S_HEAD, then
// S_REP loads the reports in pad order, skipping the pads that the scan did not mark.
// Reset (asynchronous, active low) idles the sequencer, pads type 0.
module psx_pad_multitap_poller_core #(
    parameter int PAD_COUNT = ppmp_pkg::PAD_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ppmp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ppmp_pkg::result_t result
);

    localparam int         PAD_W      = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam logic [5:0] FRAME2_LEN = 6'(ppmp_pkg::FRAME2_HEAD + 8 * PAD_COUNT);

    typedef enum logic [2:0] {S_IDLE, S_STEP, S_SCAN, S_HEAD, S_REP} state_t;

    state_t                 state_reg, state_next;
    ppmp_pkg::item_t        item_reg, item_next;
    logic [5:0]             seq_reg, seq_next;
    logic                   second_reg, second_next;
    logic                   mtap_reg, mtap_next;
    logic [PAD_W-1:0]       pad_cnt_reg, pad_cnt_next;
    logic [PAD_COUNT-1:0]   mask_reg, mask_next;
    logic                   out_valid_reg, out_valid_next;
    ppmp_pkg::result_t      out_reg, out_next;

    ppmp_pkg::store_cmd_t   store_cmd;
    ppmp_pkg::pad_bytes_t   rd_bytes;
    logic                   scan_hit;
    ppmp_pkg::result_t      report;
    logic                   out_free;
    logic [5:0]             idx;
    logic [5:0]             k;

    function automatic ppmp_pkg::result_t mk_cmd(logic [7:0] cmd, logic [1:0] ctl, logic last);
        ppmp_pkg::result_t r;
        r             = '0;
        r.result_kind = ppmp_pkg::RESULT_CMD;
        r.cmd_byte    = cmd;
        r.frame_ctl   = ctl;
        r.last        = last;
        return r;
    endfunction

    ppmp_pad_store #(.PAD_COUNT(PAD_COUNT)) u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (store_cmd),
        .rd_bytes (rd_bytes),
        .scan_hit (scan_hit)
    );

    ppmp_report_fmt u_fmt
    (
        .bytes  (rd_bytes),
        .pad    (2'(pad_cnt_reg)),
        .report (report)
    );

    assign out_free     = !out_valid_reg || !result_stall;
    assign idx          = seq_reg - 6'd1;
    assign k            = seq_reg - 6'd4;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        logic [PAD_COUNT-1:0] rest;
        state_next     = state_reg;
        item_next      = item_reg;
        seq_next       = seq_reg;
        second_next    = second_reg;
        mtap_next      = mtap_reg;
        pad_cnt_next   = pad_cnt_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        store_cmd      = '0;
        store_cmd.pad  = 2'(pad_cnt_reg);
        store_cmd.data = item_reg.rx_byte;
        rest           = mask_reg;
        rest[pad_cnt_reg] = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (item_reg.kind == ppmp_pkg::KIND_START)
                    begin
                        seq_next       = 6'd1;
                        second_next    = 1'b0;
                        out_valid_next = 1'b1;
                        out_next       = mk_cmd(ppmp_pkg::CMD_START, ppmp_pkg::FRAME_CONT, 1'b1);
                    end
                    else if (seq_reg == 6'd0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!second_reg)
                    begin
                        store_cmd.wr_en = (idx == 6'd1) || (idx >= 6'd3);
                        store_cmd.pad   = 2'd0;
                        store_cmd.off   = (idx == 6'd1) ? 3'd0 : 3'(idx - 6'd1);
                        out_valid_next  = 1'b1;
                        if (seq_reg >= ppmp_pkg::FRAME1_LEN)
                        begin
                            second_next = 1'b1;
                            seq_next    = 6'd1;
                            out_next    = mk_cmd(ppmp_pkg::CMD_START, ppmp_pkg::FRAME_NEW, 1'b1);
                        end
                        else
                        begin
                            seq_next = seq_reg + 6'd1;
                            out_next = mk_cmd((seq_reg == 6'd1) ? ppmp_pkg::CMD_POLL :
                                              ((seq_reg == 6'd2) ? ppmp_pkg::CMD_MTAP :
                                               ppmp_pkg::CMD_NONE),
                                              ppmp_pkg::FRAME_CONT, 1'b1);
                        end
                    end
                    else
                    begin
                        if (idx == 6'd1)
                        begin
                            mtap_next = (item_reg.rx_byte == ppmp_pkg::MTAP_ID);
                        end
                        store_cmd.wr_en = (idx >= 6'd3);
                        store_cmd.pad   = k[4:3];
                        store_cmd.off   = k[2:0];
                        if (((seq_reg >= ppmp_pkg::FRAME2_HEAD) && !mtap_reg) ||
                            (seq_reg >= FRAME2_LEN))
                        begin
                            seq_next     = 6'd0;
                            second_next  = 1'b0;
                            pad_cnt_next = '0;
                            state_next   = S_SCAN;
                        end
                        else
                        begin
                            seq_next       = seq_reg + 6'd1;
                            out_valid_next = 1'b1;
                            out_next       = mk_cmd((seq_reg == 6'd1) ? ppmp_pkg::CMD_POLL :
                                                    ppmp_pkg::CMD_NONE,
                                                    ppmp_pkg::FRAME_CONT, 1'b1);
                        end
                    end
                end
            end
            S_SCAN:
            begin
                store_cmd.scan_en      = 1'b1;
                mask_next[pad_cnt_reg] = scan_hit;
                if (pad_cnt_reg == PAD_W'(PAD_COUNT - 1))
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    pad_cnt_next = pad_cnt_reg + 1'b1;
                end
            end
            S_HEAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = mk_cmd(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_DONE,
                                            (mask_reg == '0));
                    pad_cnt_next   = '0;
                    state_next     = (mask_reg == '0) ? S_IDLE : S_REP;
                end
            end
            S_REP:
            begin
                if (!mask_reg[pad_cnt_reg])
                begin
                    pad_cnt_next = pad_cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = report;
                    out_next.last  = (rest == '0);
                    mask_next      = rest;
                    pad_cnt_next   = pad_cnt_reg + 1'b1;
                    if (rest == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            seq_reg       <= '0;
            second_reg    <= 1'b0;
            mtap_reg      <= 1'b0;
            pad_cnt_reg   <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            seq_reg       <= seq_next;
            second_reg    <= second_next;
            mtap_reg      <= mtap_next;
            pad_cnt_reg   <= pad_cnt_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

>>> tb/psx_pad_multitap_poller_core_test.sv
// Testbench for the pad poller with multitap: a directed table, then random polls, each
// word checked against a predictor of the command sequence and the pad reports.
// Depends on ppmp_pkg and psx_pad_multitap_poller_core.
module psx_pad_multitap_poller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPADS = ppmp_pkg::PAD_COUNT_DEF;
    localparam int ITEM_TARGET = 430;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_BY_PHASE [4] = '{0, 61, 0, 11};
    localparam int STALL_BY_PHASE [4] = '{0, 0, 61, 11};
    localparam int BTN_SRC [12] = '{13, 14, 15, 12, 11, 9, 10, 8, 3, 0, 2, 1};

    typedef struct {
        ppmp_pkg::item_t   word;
        bit                typed;
        ppmp_pkg::result_t want;
    } table_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    ppmp_pkg::item_t      item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    ppmp_pkg::result_t    result;

    logic [5:0]           poll_pos;
    logic                 poll_frame2;
    logic                 tap_present;
    logic [7:0]           pad_kind [NPADS];
    ppmp_pkg::pad_bytes_t pad_now [NPADS];
    ppmp_pkg::pad_bytes_t pad_sent [NPADS];
    ppmp_pkg::result_t    step_results [$];
    ppmp_pkg::result_t    due_results [$];
    logic [7:0]           gen_frame [NPADS][8];
    table_row_t           dir_rows [17];

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned answered_items = 0;
    int unsigned mismatches = 0;
    int unsigned hold_left = 0;
    logic        hold_request = 1'b0;
    logic        hold_done = 1'b0;

    psx_pad_multitap_poller_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic ppmp_pkg::result_t cmd_result(logic [7:0] cmd, logic [1:0] ctl);
        ppmp_pkg::result_t r;
        r = '0;
        r.result_kind = ppmp_pkg::RESULT_CMD;
        r.cmd_byte = cmd;
        r.frame_ctl = ctl;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic string result_text(ppmp_pkg::result_t r);
        return $sformatf({"kind=%0d cmd=%h ctl=%0d pad=%0d btn=%h menu=%0d hat=%0d",
                          " lx=%h ly=%h rx=%h ry=%h last=%0d"},
                         r.result_kind, r.cmd_byte, r.frame_ctl, r.pad_index, r.buttons,
                         r.menu, r.hat, r.left_x, r.left_y, r.right_x, r.right_y, r.last);
    endfunction

    function automatic void store_pad_byte(int unsigned p, int unsigned o, logic [7:0] b);
        if (p >= NPADS)
            return;
        if (o == 0)
            pad_kind[p] = b;
        else if (o == 2 || o == 3)
            pad_now[p][o - 2] = ~b;
        else if (o >= 4 && o <= 7)
            pad_now[p][o - 2] = b;
    endfunction

    // Works out the words that one accepted input word causes, into step_results.
    function automatic void predict_poll_step(ppmp_pkg::item_t w);
        int unsigned       idx;
        int unsigned       pos;
        int unsigned       k;
        logic              analog;
        logic [15:0]       pw;
        ppmp_pkg::result_t r;
        ppmp_pkg::result_t reps [$];
        step_results.delete();
        if (w.kind == ppmp_pkg::KIND_START)
        begin
            poll_pos = 6'd1;
            poll_frame2 = 1'b0;
            step_results.push_back(cmd_result(ppmp_pkg::CMD_START, ppmp_pkg::FRAME_CONT));
            return;
        end
        if (poll_pos == 6'd0)
            return;
        idx = poll_pos - 1;
        pos = poll_pos;
        if (!poll_frame2)
        begin
            if (idx == 1)
                pad_kind[0] = w.rx_byte;
            else if (idx >= 3)
                store_pad_byte(0, idx - 1, w.rx_byte);
            if (pos >= ppmp_pkg::FRAME1_LEN)
            begin
                poll_frame2 = 1'b1;
                poll_pos = 6'd1;
                step_results.push_back(cmd_result(ppmp_pkg::CMD_START, ppmp_pkg::FRAME_NEW));
            end
            else
            begin
                poll_pos = 6'(pos + 1);
                step_results.push_back(cmd_result(pos == 1 ? ppmp_pkg::CMD_POLL :
                                                  pos == 2 ? ppmp_pkg::CMD_MTAP :
                                                  ppmp_pkg::CMD_NONE,
                                                  ppmp_pkg::FRAME_CONT));
            end
            return;
        end
        if (idx == 1)
            tap_present = (w.rx_byte == ppmp_pkg::MTAP_ID);
        else if (idx >= ppmp_pkg::FRAME2_HEAD)
        begin
            k = idx - ppmp_pkg::FRAME2_HEAD;
            store_pad_byte(k >> 3, k & 7, w.rx_byte);
        end
        if ((pos >= ppmp_pkg::FRAME2_HEAD && !tap_present) ||
            pos >= ppmp_pkg::FRAME2_HEAD + 8 * NPADS)
        begin
            for (int p = 0; p < NPADS; p++)
            begin
                analog = (pad_kind[p] == ppmp_pkg::TYPE_ANALOG ||
                          pad_kind[p] == ppmp_pkg::TYPE_ANAGRN);
                if (!analog)
                    for (int o = 2; o < ppmp_pkg::STATE_BYTES; o++)
                        pad_now[p][o] = ppmp_pkg::AXIS_CENTRE;
                if ((analog || pad_kind[p] == ppmp_pkg::TYPE_DIGITAL) &&
                    pad_now[p] != pad_sent[p])
                begin
                    pad_sent[p] = pad_now[p];
                    r = '0;
                    r.result_kind = ppmp_pkg::RESULT_REPORT;
                    r.pad_index = p[1:0];
                    pw = {pad_now[p][1], pad_now[p][0]};
                    if (pw[3] && pw[0])
                        r.menu = 1'b1;
                    else
                        for (int i = 0; i < 12; i++)
                            r.buttons[i] = pw[BTN_SRC[i]];
                    if (pw[6])
                        r.hat = pw[5] ? ppmp_pkg::HAT_DOWN_RIGHT :
                                pw[7] ? ppmp_pkg::HAT_DOWN_LEFT : ppmp_pkg::HAT_DOWN;
                    else if (pw[4])
                        r.hat = pw[5] ? ppmp_pkg::HAT_UP_RIGHT :
                                pw[7] ? ppmp_pkg::HAT_UP_LEFT : ppmp_pkg::HAT_UP;
                    else if (pw[5])
                        r.hat = ppmp_pkg::HAT_RIGHT;
                    else if (pw[7])
                        r.hat = ppmp_pkg::HAT_LEFT;
                    else
                        r.hat = ppmp_pkg::HAT_CENTRE;
                    r.left_x = pad_now[p][4];
                    r.left_y = pad_now[p][5];
                    r.right_x = pad_now[p][2];
                    r.right_y = pad_now[p][3];
                    reps.push_back(r);
                end
            end
            r = cmd_result(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_DONE);
            r.last = (reps.size() == 0);
            step_results.push_back(r);
            foreach (reps[i])
            begin
                r = reps[i];
                r.last = (i == reps.size() - 1);
                step_results.push_back(r);
            end
            poll_pos = 6'd0;
            poll_frame2 = 1'b0;
        end
        else
        begin
            poll_pos = 6'(pos + 1);
            step_results.push_back(cmd_result(pos == 1 ? ppmp_pkg::CMD_POLL : ppmp_pkg::CMD_NONE,
                                              ppmp_pkg::FRAME_CONT));
        end
    endfunction

    task automatic send_word(input ppmp_pkg::item_t w, input bit typed,
                             input ppmp_pkg::result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_poll_step(w);
        if (typed)
            due_results.push_back(want);
        else
            foreach (step_results[i])
                due_results.push_back(step_results[i]);
        if (step_results.size() > 0)
            answered_items++;
    endtask

    task automatic send_rx(input logic kind, input logic [7:0] b);
        ppmp_pkg::item_t w;
        w.kind = kind;
        w.rx_byte = b;
        send_word(w, 1'b0, '0);
    endtask

    task automatic random_poll();
        int unsigned choice;
        int unsigned pick;
        logic        tap;
        choice = $urandom_range(99);
        if (choice < 8)
        begin
            repeat ($urandom_range(1, 5))
                send_rx(1'($urandom_range(1)), 8'($urandom_range(255)));
            return;
        end
        send_rx(ppmp_pkg::KIND_START, 8'($urandom_range(255)));
        if (choice < 16)
        begin
            repeat ($urandom_range(1, 40))
                send_rx(ppmp_pkg::KIND_BYTE, 8'($urandom_range(255)));
            return;
        end
        for (int p = 0; p < NPADS; p++)
        begin
            if ($urandom_range(99) < 70)
            begin
                pick = $urandom_range(9);
                gen_frame[p][0] = pick < 3 ? ppmp_pkg::TYPE_ANALOG :
                                  pick < 5 ? ppmp_pkg::TYPE_ANAGRN :
                                  pick < 7 ? ppmp_pkg::TYPE_DIGITAL : 8'($urandom_range(255));
                for (int o = 1; o < 8; o++)
                    gen_frame[p][o] = 8'($urandom_range(255));
                if ($urandom_range(9) == 0)
                begin
                    gen_frame[p][2] = 8'hFF;
                    gen_frame[p][3] = 8'hFF;
                end
            end
        end
        send_rx(ppmp_pkg::KIND_BYTE, 8'($urandom_range(255)));
        for (int o = 0; o < 8; o++)
            send_rx(ppmp_pkg::KIND_BYTE, gen_frame[0][o]);
        tap = ($urandom_range(1) == 1);
        send_rx(ppmp_pkg::KIND_BYTE, 8'($urandom_range(255)));
        send_rx(ppmp_pkg::KIND_BYTE, tap ? ppmp_pkg::MTAP_ID : 8'($urandom_range(255)));
        send_rx(ppmp_pkg::KIND_BYTE, 8'($urandom_range(255)));
        if (tap)
            for (int p = 0; p < NPADS; p++)
                for (int o = 0; o < 8; o++)
                    send_rx(ppmp_pkg::KIND_BYTE, gen_frame[p][o]);
    endtask

    always @(posedge clk)
    begin
        ppmp_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %s", result_text(result));
            end
            else
            begin
                want = due_results.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch\n  expected %s\n  actual   %s",
                                 result_text(want), result_text(result));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        poll_pos = 6'd0;
        poll_frame2 = 1'b0;
        tap_present = 1'b0;
        for (int p = 0; p < NPADS; p++)
        begin
            pad_kind[p] = 8'h00;
            pad_now[p] = ppmp_pkg::BYTES_RESET;
            pad_sent[p] = ppmp_pkg::BYTES_RESET;
            for (int o = 0; o < 8; o++)
                gen_frame[p][o] = 8'h00;
        end
        dir_rows = '{
            '{'{ppmp_pkg::KIND_BYTE, 8'hFF}, 1'b0, '0},
            '{'{ppmp_pkg::KIND_START, 8'h00}, 1'b1,
              cmd_result(ppmp_pkg::CMD_START, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'h00}, 1'b1,
              cmd_result(ppmp_pkg::CMD_POLL, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, ppmp_pkg::TYPE_ANALOG}, 1'b1,
              cmd_result(ppmp_pkg::CMD_MTAP, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'h5A}, 1'b1,
              cmd_result(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'h00}, 1'b1,
              cmd_result(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'h00}, 1'b1,
              cmd_result(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'h00}, 1'b1,
              cmd_result(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'hFF}, 1'b1,
              cmd_result(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'h00}, 1'b1,
              cmd_result(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'hFF}, 1'b1,
              cmd_result(ppmp_pkg::CMD_START, ppmp_pkg::FRAME_NEW)},
            '{'{ppmp_pkg::KIND_BYTE, 8'hFF}, 1'b1,
              cmd_result(ppmp_pkg::CMD_POLL, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'h5A}, 1'b1,
              cmd_result(ppmp_pkg::CMD_NONE, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'hFF}, 1'b0, '0},
            '{'{ppmp_pkg::KIND_START, 8'hFF}, 1'b1,
              cmd_result(ppmp_pkg::CMD_START, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_BYTE, 8'h00}, 1'b1,
              cmd_result(ppmp_pkg::CMD_POLL, ppmp_pkg::FRAME_CONT)},
            '{'{ppmp_pkg::KIND_START, 8'h00}, 1'b1,
              cmd_result(ppmp_pkg::CMD_START, ppmp_pkg::FRAME_CONT)}
        };
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        answered_items = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = IDLE_BY_PHASE[phase];
            stall_pct = STALL_BY_PHASE[phase];
            while (answered_items < (phase + 1) * ITEM_TARGET / 4)
            begin
                if (phase == 0 && answered_items > 40)
                    hold_request <= 1'b1;
                random_poll();
            end
        end
        item_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (64)
            @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> psx_pad_multitap_poller_core.f
design/ppmp_pkg.sv
design/ppmp_report_fmt.sv
design/ppmp_pad_store.sv
design/psx_pad_multitap_poller_core.sv
tb/psx_pad_multitap_poller_core_test.sv
